### rtl/sdtq_pkg.sv
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 48;
    localparam int MAX_FIRES  = 32;

    localparam int ID_W     = 4;
    localparam int PERIOD_W = 32;
    localparam int IDX_W    = $clog2(NUM_TIMERS);
    localparam int CNT_W    = $clog2(NUM_TIMERS + 1);
    localparam int FIRE_W   = $clog2(MAX_FIRES + 1);

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(1);

    typedef enum logic [1:0] {
        MODE_ONESHOT  = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_DELETE   = 2'd2,
        MODE_CHECK    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_FIRE    = 2'd1,
        KIND_SUMMARY = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REM,
        S_ARM,
        S_PHASE,
        S_SUM,
        S_INS,
        S_CHK,
        S_EMIT
    } t_state;

    // array update strobes from the sequencer
    typedef struct packed {
        logic             accept;
        logic             rem_en;
        logic [IDX_W-1:0] rem_pos;
        logic             set_entry;
        logic             dl_wr;
        logic             ins_en;
        logic             load_out;
    } t_ctl;

endpackage

### rtl/sdtq_req_if.sv
`timescale 1ns / 1ps

interface sdtq_req_if;
    logic                                valid;
    logic                                ready;
    sdtq_pkg::t_mode                     mode;
    logic [sdtq_pkg::ID_W-1:0]           timer_id;
    logic [sdtq_pkg::PERIOD_W-1:0]       interval;
    logic [sdtq_pkg::TIME_BITS-1:0]      now;

    modport source (output valid, mode, timer_id, interval, now, input ready);
    modport sink   (input valid, mode, timer_id, interval, now, output ready);
endinterface

### rtl/sdtq_rsp_if.sv
`timescale 1ns / 1ps

interface sdtq_rsp_if;
    logic                                valid;
    logic                                ready;
    sdtq_pkg::t_kind                     kind;
    logic [sdtq_pkg::ID_W-1:0]           fired_id;
    logic [sdtq_pkg::TIME_BITS-1:0]      next_deadline;
    logic                                head_changed;
    logic                                queue_empty;
    logic                                more_pending;
    logic                                last;

    modport source (output valid, kind, fired_id, next_deadline, head_changed, queue_empty,
                    more_pending, last, input ready);
    modport sink   (input valid, kind, fired_id, next_deadline, head_changed, queue_empty,
                    more_pending, last, output ready);
endinterface

### rtl/sorted_deadline_timer_queue_core.sv
`timescale 1ns / 1ps

// Sorted deadline timer queue.
// i_req (valid/ready) takes one request: add one-shot, add periodic, delete or
// check against the current time. o_rsp (valid/ready) returns its results; the
// result with last set closes the request. A check returns one fire result per
// expired timer (at most MAX_FIRES) and then a summary.
// i_cfg_we / i_cfg_wdata write min_period; the user must do so only while the block
// is idle, which the block does not enforce. One request is worked at a time;
// i_req.ready is high only between requests. A single scan index walks the order
// slots with one 48-bit compare unit. A delete scans for the timer and removes it;
// an add removes it, searches for a phase (periodic timer with zero deadline), sums
// the deadline and inserts it; a check removes each expired timer from the head and
// re-arms periodic ones through phase search, sum and insert.
// Each result sits in an output register; when the receiver stalls the
// sequencer waits on that register, and the next request can be taken while
// the final result of the previous one is still waiting.
// Reset (synchronous, active low) empties the queue, clears all timer entries
// and sets min_period to 1.
module sorted_deadline_timer_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdtq_pkg::PERIOD_W-1:0]     i_cfg_wdata,
    sdtq_req_if.sink                          i_req,
    sdtq_rsp_if.source                        o_rsp
);

    localparam int N  = sdtq_pkg::NUM_TIMERS;
    localparam int TB = sdtq_pkg::TIME_BITS;
    localparam int PW = sdtq_pkg::PERIOD_W;
    localparam int IW = sdtq_pkg::IDX_W;
    localparam int CW = sdtq_pkg::CNT_W;
    localparam int FW = sdtq_pkg::FIRE_W;

    sdtq_pkg::t_state r_state, n_state;
    sdtq_pkg::t_ctl   ctl;

    logic [PW-1:0] r_min_period;

    logic [TB-1:0] r_dl      [N];
    logic [PW-1:0] r_period  [N];
    logic [N-1:0]  r_periodic;
    logic [N-1:0]  r_queued;
    logic [IW-1:0] r_slots   [N];
    logic [CW-1:0] r_count;

    sdtq_pkg::t_mode        r_mode;
    logic [sdtq_pkg::ID_W-1:0] r_tid;
    logic [PW-1:0]          r_interval;
    logic [TB-1:0]          r_now;
    logic [IW-1:0]          r_id;
    logic [CW-1:0]          r_idx;
    logic [TB-1:0]          r_base;
    logic [PW-1:0]          r_per;
    logic [TB-1:0]          r_d;
    logic [FW-1:0]          r_nfire;
    sdtq_pkg::t_kind        r_kind;
    logic                   r_hc;
    logic                   r_more;
    logic                   r_last;

    logic                   r_ovalid;
    sdtq_pkg::t_kind        r_o_kind;
    logic [sdtq_pkg::ID_W-1:0] r_o_fid;
    logic [TB-1:0]          r_o_nd;
    logic                   r_o_hc;
    logic                   r_o_empty;
    logic                   r_o_more;
    logic                   r_o_last;

    // shared read ports and compare unit
    logic [IW-1:0] slot_cur, head_id, dl_addr, pd_addr;
    logic [TB-1:0] dl_rd, cmp_b;
    logic [PW-1:0] per_rd, per_new;
    logic          pdc_rd;
    logic          gt, scan_end, id_bad, can_load;
    logic [TB:0]   sum;
    logic [TB-1:0] sat_d;

    always_comb begin
        slot_cur = r_slots[r_idx[IW-1:0]];
        head_id  = r_slots[0];
        scan_end = (r_idx == r_count);
        unique case (r_state)
            sdtq_pkg::S_ARM:               dl_addr = r_id;
            sdtq_pkg::S_PHASE, sdtq_pkg::S_INS: dl_addr = slot_cur;
            default:                       dl_addr = head_id;
        endcase
        unique case (r_state)
            sdtq_pkg::S_ARM:   pd_addr = r_id;
            sdtq_pkg::S_PHASE: pd_addr = slot_cur;
            default:           pd_addr = head_id;
        endcase
        dl_rd  = r_dl[dl_addr];
        per_rd = r_period[pd_addr];
        pdc_rd = r_periodic[pd_addr];
        cmp_b  = (r_state == sdtq_pkg::S_CHK) ? r_now : r_d;
        gt     = (dl_rd > cmp_b);
        sum    = {1'b0, r_base} + (TB + 1)'(r_per);
        sat_d  = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
        id_bad = (32'(r_tid) >= N) ||
                 ((r_mode == sdtq_pkg::MODE_PERIODIC) && (r_interval < r_min_period));
        per_new = ((r_mode == sdtq_pkg::MODE_ONESHOT) && (r_interval == '0))
                  ? PW'(1) : r_interval;
        can_load = !r_ovalid || o_rsp.ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdtq_pkg::S_IDLE:
                if (i_req.valid) n_state = sdtq_pkg::S_DECODE;
            sdtq_pkg::S_DECODE: begin
                if (r_mode == sdtq_pkg::MODE_CHECK) n_state = sdtq_pkg::S_CHK;
                else if (id_bad)                    n_state = sdtq_pkg::S_EMIT;
                else                                n_state = sdtq_pkg::S_REM;
            end
            sdtq_pkg::S_REM:
                if (scan_end || slot_cur == r_id) begin
                    n_state = (r_mode == sdtq_pkg::MODE_DELETE) ? sdtq_pkg::S_EMIT
                                                                : sdtq_pkg::S_ARM;
                end
            sdtq_pkg::S_ARM:
                n_state = (r_periodic[r_id] && dl_rd == '0) ? sdtq_pkg::S_PHASE
                                                            : sdtq_pkg::S_SUM;
            sdtq_pkg::S_PHASE:
                if (scan_end || (pdc_rd && per_rd == r_per)) n_state = sdtq_pkg::S_SUM;
            sdtq_pkg::S_SUM:
                n_state = sdtq_pkg::S_INS;
            sdtq_pkg::S_INS:
                if (scan_end || gt) n_state = sdtq_pkg::S_EMIT;
            sdtq_pkg::S_CHK: begin
                if (r_count == '0 || gt || r_nfire == FW'(sdtq_pkg::MAX_FIRES))
                    n_state = sdtq_pkg::S_EMIT;
                else if (pdc_rd)
                    n_state = sdtq_pkg::S_ARM;
                else
                    n_state = sdtq_pkg::S_EMIT;
            end
            sdtq_pkg::S_EMIT:
                if (can_load) n_state = r_last ? sdtq_pkg::S_IDLE : sdtq_pkg::S_CHK;
            default:
                n_state = sdtq_pkg::S_IDLE;
        endcase
    end

    // array strobes
    always_comb begin
        ctl = '0;
        unique case (r_state)
            sdtq_pkg::S_IDLE:  ctl.accept = i_req.valid;
            sdtq_pkg::S_REM: begin
                ctl.rem_en    = !scan_end && (slot_cur == r_id);
                ctl.rem_pos   = r_idx[IW-1:0];
                ctl.set_entry = (scan_end || slot_cur == r_id) &&
                                (r_mode != sdtq_pkg::MODE_DELETE);
            end
            sdtq_pkg::S_SUM:   ctl.dl_wr = 1'b1;
            sdtq_pkg::S_INS:   ctl.ins_en = scan_end || gt;
            sdtq_pkg::S_CHK: begin
                ctl.rem_en  = (r_count != '0) && !gt &&
                              (r_nfire != FW'(sdtq_pkg::MAX_FIRES));
                ctl.rem_pos = '0;
            end
            sdtq_pkg::S_EMIT:  ctl.load_out = can_load;
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == sdtq_pkg::S_IDLE);

    // control and sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sdtq_pkg::S_IDLE;
            r_min_period <= sdtq_pkg::MIN_PERIOD_RST;
            r_count      <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_min_period <= i_cfg_wdata;
            if (ctl.rem_en) r_count <= r_count - CW'(1);
            else if (ctl.ins_en) r_count <= r_count + CW'(1);
            if (ctl.load_out) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end

    // timer entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) begin
                r_dl[j]     <= '0;
                r_period[j] <= '0;
            end
            r_periodic <= '0;
            r_queued   <= '0;
        end else begin
            if (ctl.rem_en) r_queued[(r_state == sdtq_pkg::S_CHK) ? head_id : r_id] <= 1'b0;
            if (ctl.ins_en) r_queued[r_id] <= 1'b1;
            if (ctl.set_entry) begin
                r_periodic[r_id] <= (r_mode == sdtq_pkg::MODE_PERIODIC);
                r_period[r_id]   <= per_new;
            end
            if (ctl.dl_wr) r_dl[r_id] <= sat_d;
        end
    end

    // order slots: shift out on removal, shift in on insertion
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N; j++) begin
            if (ctl.rem_en && IW'(j) >= ctl.rem_pos) begin
                if (j < N - 1) r_slots[j] <= r_slots[(j + 1) % N];
            end else if (ctl.ins_en) begin
                if (IW'(j) == r_idx[IW-1:0])     r_slots[j] <= r_id;
                else if (IW'(j) > r_idx[IW-1:0]) r_slots[j] <= r_slots[(j + N - 1) % N];
            end
        end
    end

    // request data and result fields
    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_mode     <= i_req.mode;
            r_tid      <= i_req.timer_id;
            r_interval <= i_req.interval;
            r_now      <= i_req.now;
            r_nfire    <= '0;
        end
        unique case (r_state)
            sdtq_pkg::S_DECODE: begin
                r_id   <= r_tid[IW-1:0];
                r_idx  <= '0;
                r_kind <= sdtq_pkg::KIND_ERROR;
                r_hc   <= 1'b0;
                r_more <= 1'b0;
                r_last <= 1'b1;
            end
            sdtq_pkg::S_REM: begin
                if (scan_end || slot_cur == r_id) begin
                    r_kind <= sdtq_pkg::KIND_ACK;
                    r_hc   <= !scan_end && (r_idx == '0) && (r_count > CW'(1));
                    r_per  <= per_new;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            sdtq_pkg::S_ARM: begin
                r_idx  <= '0;
                r_base <= (r_periodic[r_id] && dl_rd != '0) ? dl_rd : r_now;
            end
            sdtq_pkg::S_PHASE: begin
                if (!scan_end && pdc_rd && per_rd == r_per) r_base <= dl_rd;
                else if (!scan_end) r_idx <= r_idx + CW'(1);
            end
            sdtq_pkg::S_SUM: begin
                r_d   <= sat_d;
                r_idx <= '0;
            end
            sdtq_pkg::S_INS: begin
                if (scan_end || gt) begin
                    if (r_mode == sdtq_pkg::MODE_CHECK) begin
                        r_kind <= sdtq_pkg::KIND_FIRE;
                        r_hc   <= 1'b0;
                        r_last <= 1'b0;
                    end else begin
                        r_kind <= sdtq_pkg::KIND_ACK;
                        r_hc   <= (r_idx == '0);
                        r_last <= 1'b1;
                    end
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            sdtq_pkg::S_CHK: begin
                if (ctl.rem_en) begin
                    r_id    <= head_id;
                    r_per   <= per_rd;
                    r_nfire <= r_nfire + FW'(1);
                    r_kind  <= sdtq_pkg::KIND_FIRE;
                    r_hc    <= 1'b0;
                    r_more  <= 1'b0;
                    r_last  <= 1'b0;
                end else begin
                    // summary; r_more marks a fire limit hit while the head is due
                    r_kind <= sdtq_pkg::KIND_SUMMARY;
                    r_hc   <= (r_count != '0);
                    r_more <= (r_count != '0) && !gt;
                    r_last <= 1'b1;
                end
            end
            default: ;
        endcase
        if (ctl.load_out) begin
            r_o_kind  <= r_kind;
            r_o_fid   <= (r_kind == sdtq_pkg::KIND_FIRE) ? sdtq_pkg::ID_W'(r_id) : '0;
            r_o_nd    <= (r_count == '0) ? '0 : dl_rd;
            r_o_hc    <= r_hc;
            r_o_empty <= (r_count == '0);
            r_o_more  <= r_more;
            r_o_last  <= r_last;
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.kind          = r_o_kind;
    assign o_rsp.fired_id      = r_o_fid;
    assign o_rsp.next_deadline = r_o_nd;
    assign o_rsp.head_changed  = r_o_hc;
    assign o_rsp.queue_empty   = r_o_empty;
    assign o_rsp.more_pending  = r_o_more;
    assign o_rsp.last          = r_o_last;

`ifndef NO_ASSERTIONS
    a_count_matches_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_queued) == 32'(r_count))
        else $error("queue count out of step with queued flags");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N))
        else $error("queue count above capacity");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state == sdtq_pkg::S_DECODE)
        else $error("accepted request not decoded");

    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.kind == sdtq_pkg::KIND_FIRE |-> !o_rsp.last && !o_rsp.more_pending)
        else $error("fire result closes the request");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PER_PHASE = 30;

    typedef logic [sdtq_pkg::TIME_BITS-1:0] t_tick;

    typedef enum logic [1:0] {
        ACT_REQ,
        ACT_CFG,
        ACT_DRAIN,
        ACT_HOLD
    } t_stim_act;

    typedef struct {
        t_stim_act                       act;
        sdtq_pkg::t_mode                 mode;
        logic [sdtq_pkg::ID_W-1:0]       id;
        logic [sdtq_pkg::PERIOD_W-1:0]   ival;   // also the min_period value for ACT_CFG
        t_tick                           tick;
    } t_stim;

    typedef struct {
        sdtq_pkg::t_kind             kind;
        logic [sdtq_pkg::ID_W-1:0]   fired_id;
        t_tick                       next_deadline;
        logic                        head_changed;
        logic                        queue_empty;
        logic                        more_pending;
        logic                        last;
    } t_timer_rsp;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [sdtq_pkg::PERIOD_W-1:0] cfg_wdata = '0;

    sdtq_req_if req_if ();
    sdtq_rsp_if rsp_if ();

    sorted_deadline_timer_queue_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Timer queue shadow
    // ---------------------------------------------------------------
    t_tick                         tq_deadline [sdtq_pkg::NUM_TIMERS];
    logic [sdtq_pkg::PERIOD_W-1:0] tq_period   [sdtq_pkg::NUM_TIMERS];
    logic                          tq_periodic [sdtq_pkg::NUM_TIMERS];
    logic                          tq_queued   [sdtq_pkg::NUM_TIMERS];
    logic [sdtq_pkg::IDX_W-1:0]    tq_order    [sdtq_pkg::NUM_TIMERS];
    int                            tq_count;
    logic [sdtq_pkg::PERIOD_W-1:0] tq_min_period;

    t_timer_rsp expected_rsp_q[$];
    t_stim      stim_q[$];

    logic rsp_drained = 1'b1;
    logic feed_idle = 1'b0;
    logic hold_kick = 1'b0;
    int   fail_cnt = 0;

    function automatic t_tick sat_sum(t_tick a, logic [sdtq_pkg::PERIOD_W-1:0] b);
        logic [sdtq_pkg::TIME_BITS:0] s;
        s = {1'b0, a} + b;
        return s[sdtq_pkg::TIME_BITS] ? '1 : s[sdtq_pkg::TIME_BITS-1:0];
    endfunction

    // returns the slot the timer left, NUM_TIMERS if it was not queued
    function automatic int unlink_timer(int id);
        int pos;
        int i;
        pos = sdtq_pkg::NUM_TIMERS;
        for (i = 0; i < tq_count; i++) begin
            if (tq_order[i] == id) begin
                pos = i;
                break;
            end
        end
        if (pos < sdtq_pkg::NUM_TIMERS) begin
            for (i = pos; i < tq_count - 1; i++)
                tq_order[i] = tq_order[i + 1];
            tq_count--;
            tq_queued[id] = 1'b0;
        end
        return pos;
    endfunction

    function automatic int arm_timer(int id, t_tick tick);
        t_tick base;
        t_tick dl;
        int    pos;
        int    i;
        if (tq_periodic[id]) begin
            base = tq_deadline[id];
            if (base == '0) begin
                // phase follows the first queued periodic timer of equal period
                base = tick;
                for (i = 0; i < tq_count; i++) begin
                    if (tq_periodic[tq_order[i]] && tq_period[tq_order[i]] == tq_period[id]) begin
                        base = tq_deadline[tq_order[i]];
                        break;
                    end
                end
            end
            dl = sat_sum(base, tq_period[id]);
        end else begin
            dl = sat_sum(tick, tq_period[id]);
        end
        tq_deadline[id] = dl;
        if (tq_count >= sdtq_pkg::NUM_TIMERS)
            return sdtq_pkg::NUM_TIMERS;
        pos = tq_count;
        for (i = 0; i < tq_count; i++) begin
            if (tq_deadline[tq_order[i]] > dl) begin
                pos = i;
                break;
            end
        end
        for (i = tq_count; i > pos; i--)
            tq_order[i] = tq_order[i - 1];
        tq_order[pos] = sdtq_pkg::IDX_W'(id);
        tq_count++;
        tq_queued[id] = 1'b1;
        return pos;
    endfunction

    function automatic void push_result(sdtq_pkg::t_kind kind, int fid, logic hc, logic more,
                                        logic lst);
        t_timer_rsp r;
        r.kind          = kind;
        r.fired_id      = sdtq_pkg::ID_W'(fid);
        r.next_deadline = (tq_count > 0) ? tq_deadline[tq_order[0]] : '0;
        r.head_changed  = hc;
        r.queue_empty   = (tq_count == 0);
        r.more_pending  = more;
        r.last          = lst;
        expected_rsp_q.push_back(r);
    endfunction

    function automatic void model_request(sdtq_pkg::t_mode mode, logic [sdtq_pkg::ID_W-1:0] id,
                                          logic [sdtq_pkg::PERIOD_W-1:0] ival, t_tick tick);
        int   n;
        int   pos;
        int   t;
        logic more;
        if (mode == sdtq_pkg::MODE_CHECK) begin
            n = 0;
            more = 1'b0;
            while (tq_count > 0 && tq_deadline[tq_order[0]] <= tick) begin
                if (n >= sdtq_pkg::MAX_FIRES) begin
                    more = 1'b1;
                    break;
                end
                t = tq_order[0];
                void'(unlink_timer(t));
                if (tq_periodic[t])
                    void'(arm_timer(t, tick));
                push_result(sdtq_pkg::KIND_FIRE, t, 1'b0, 1'b0, 1'b0);
                n++;
            end
            push_result(sdtq_pkg::KIND_SUMMARY, 0, tq_count > 0, more, 1'b1);
        end else if (int'(id) >= sdtq_pkg::NUM_TIMERS ||
                     (mode == sdtq_pkg::MODE_PERIODIC && ival < tq_min_period)) begin
            push_result(sdtq_pkg::KIND_ERROR, 0, 1'b0, 1'b0, 1'b1);
        end else if (mode == sdtq_pkg::MODE_DELETE) begin
            pos = unlink_timer(id);
            push_result(sdtq_pkg::KIND_ACK, 0, pos == 0 && tq_count > 0, 1'b0, 1'b1);
        end else begin
            void'(unlink_timer(id));
            tq_periodic[id] = (mode == sdtq_pkg::MODE_PERIODIC);
            if (mode == sdtq_pkg::MODE_ONESHOT)
                tq_period[id] = (ival == '0) ? sdtq_pkg::PERIOD_W'(1) : ival;
            else
                tq_period[id] = ival;
            pos = arm_timer(id, tick);
            push_result(sdtq_pkg::KIND_ACK, 0, pos == 0, 1'b0, 1'b1);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk) begin : request_driver
        logic  v_n;
        logic  we_n;
        logic  kick_n;
        t_stim it;
        v_n = req_if.valid;
        we_n = 1'b0;
        kick_n = 1'b0;
        if (!rst_n) begin
            v_n = 1'b0;
            req_if.mode <= sdtq_pkg::MODE_ONESHOT;
            req_if.timer_id <= '0;
            req_if.interval <= '0;
            req_if.now <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            v_n = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (stim_q.size() > 0) begin
                it = stim_q[0];
                case (it.act)
                    ACT_REQ: begin
                        v_n = 1'b1;
                        req_if.mode <= it.mode;
                        req_if.timer_id <= it.id;
                        req_if.interval <= it.ival;
                        req_if.now <= it.tick;
                        void'(stim_q.pop_front());
                        if (burst_left <= 1) begin
                            burst_left = $urandom_range(1, 8);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        end else begin
                            burst_left--;
                        end
                    end
                    ACT_CFG: begin
                        // register writes only once every result is back
                        if (!req_if.valid && rsp_drained) begin
                            we_n = 1'b1;
                            cfg_wdata <= it.ival;
                            void'(stim_q.pop_front());
                        end
                    end
                    ACT_DRAIN: begin
                        if (!req_if.valid && rsp_drained)
                            void'(stim_q.pop_front());
                    end
                    default: begin
                        kick_n = 1'b1;
                        void'(stim_q.pop_front());
                    end
                endcase
            end
        end
        req_if.valid <= v_n;
        cfg_we <= we_n;
        hold_kick <= kick_n;
        feed_idle <= rst_n && stim_q.size() == 0 && !v_n;
    end

    // ---------------------------------------------------------------
    // Result sink: random ready segments plus one long hold-off
    // ---------------------------------------------------------------
    int hold_left = 0;
    int seg_left = 0;
    int seg_mode = 0;

    always @(posedge clk) begin : result_sink
        logic r_n;
        if (hold_kick)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            r_n = 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 120);
                seg_mode = $urandom_range(0, 2);
            end
            seg_left--;
            case (seg_mode)
                0: r_n = 1'b1;
                1: r_n = $urandom_range(0, 1);
                default: r_n = ($urandom_range(0, 3) == 0);
            endcase
        end
        rsp_if.ready <= r_n;
    end

    // ---------------------------------------------------------------
    // Monitor: shadow update on each request, compare on each result
    // ---------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_timer_rsp got;
        t_timer_rsp want;
        if (!rst_n) begin
            for (int k = 0; k < sdtq_pkg::NUM_TIMERS; k++) begin
                tq_deadline[k] = '0;
                tq_period[k] = '0;
                tq_periodic[k] = 1'b0;
                tq_queued[k] = 1'b0;
                tq_order[k] = '0;
            end
            tq_count = 0;
            tq_min_period = sdtq_pkg::MIN_PERIOD_RST;
            expected_rsp_q.delete();
        end else begin
            if (cfg_we)
                tq_min_period = cfg_wdata;
            if (req_if.valid && req_if.ready)
                model_request(req_if.mode, req_if.timer_id, req_if.interval, req_if.now);
            if (rsp_if.valid && rsp_if.ready) begin
                got.kind = rsp_if.kind;
                got.fired_id = rsp_if.fired_id;
                got.next_deadline = rsp_if.next_deadline;
                got.head_changed = rsp_if.head_changed;
                got.queue_empty = rsp_if.queue_empty;
                got.more_pending = rsp_if.more_pending;
                got.last = rsp_if.last;
                if (expected_rsp_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: unexpected result kind %0d id %0d next %h", $realtime,
                                 got.kind, got.fired_id, got.next_deadline);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
                        got.next_deadline !== want.next_deadline ||
                        got.head_changed !== want.head_changed ||
                        got.queue_empty !== want.queue_empty ||
                        got.more_pending !== want.more_pending || got.last !== want.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  exp kind %0d id %0d next %h hc %b empty %b more %b last %b",
                                     want.kind, want.fired_id, want.next_deadline,
                                     want.head_changed, want.queue_empty, want.more_pending,
                                     want.last);
                            $display("  got kind %0d id %0d next %h hc %b empty %b more %b last %b",
                                     got.kind, got.fired_id, got.next_deadline,
                                     got.head_changed, got.queue_empty, got.more_pending,
                                     got.last);
                        end
                    end
                end
            end
        end
        rsp_drained <= (expected_rsp_q.size() == 0);
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any handshake
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic queue_req(sdtq_pkg::t_mode m, int id, logic [sdtq_pkg::PERIOD_W-1:0] iv,
                             t_tick tk);
        t_stim s;
        s.act = ACT_REQ;
        s.mode = m;
        s.id = sdtq_pkg::ID_W'(id);
        s.ival = iv;
        s.tick = tk;
        stim_q.push_back(s);
    endtask

    task automatic queue_ctl(t_stim_act a, logic [sdtq_pkg::PERIOD_W-1:0] v);
        t_stim s;
        s.act = a;
        s.mode = sdtq_pkg::MODE_CHECK;
        s.id = '0;
        s.ival = v;
        s.tick = '0;
        stim_q.push_back(s);
    endtask

    initial begin
        t_tick                         t_cur;
        t_tick                         tk;
        int                            r;
        int                            ph;
        int                            n;
        logic [sdtq_pkg::PERIOD_W-1:0] iv;
        logic [sdtq_pkg::PERIOD_W-1:0] phase_min [4];

        // directed: zero time, interval 0, short period, phase sharing,
        // saturation, re-add, idle delete, head delete, fire limit
        queue_req(sdtq_pkg::MODE_CHECK, 0, 0, '0);
        queue_req(sdtq_pkg::MODE_ONESHOT, 0, 0, '0);
        queue_req(sdtq_pkg::MODE_PERIODIC, 15, 0, 48'd5);
        queue_req(sdtq_pkg::MODE_PERIODIC, 1, 100, 48'd50);
        queue_req(sdtq_pkg::MODE_PERIODIC, 2, 100, 48'd70);
        queue_req(sdtq_pkg::MODE_ONESHOT, 3, '1, '1);
        queue_req(sdtq_pkg::MODE_ONESHOT, 0, 5, 48'd10);
        queue_req(sdtq_pkg::MODE_DELETE, 9, 0, 48'd12);
        queue_req(sdtq_pkg::MODE_DELETE, 0, 0, 48'd12);
        queue_req(sdtq_pkg::MODE_CHECK, 0, 0, 48'd200);
        queue_req(sdtq_pkg::MODE_CHECK, 0, 0, '1);
        queue_req(sdtq_pkg::MODE_DELETE, 1, 0, '1);
        queue_req(sdtq_pkg::MODE_DELETE, 2, 0, '1);
        queue_req(sdtq_pkg::MODE_DELETE, 3, 0, '1);
        queue_ctl(ACT_CFG, '1);
        queue_req(sdtq_pkg::MODE_PERIODIC, 4, 32'hFFFF_FFFE, 48'd1);
        queue_req(sdtq_pkg::MODE_PERIODIC, 4, '1, 48'd1);
        queue_ctl(ACT_CFG, '0);
        queue_req(sdtq_pkg::MODE_PERIODIC, 5, 0, '0);
        queue_req(sdtq_pkg::MODE_CHECK, 0, 0, '0);
        queue_req(sdtq_pkg::MODE_DELETE, 5, 0, 48'd1);
        queue_req(sdtq_pkg::MODE_DELETE, 4, 0, 48'd1);

        phase_min = '{32'd7, 32'd0, 32'd30, 32'd1};
        t_cur = t_tick'($urandom_range(1000, 100000));
        for (ph = 0; ph < 4; ph++) begin
            queue_ctl(ACT_CFG, phase_min[ph]);
            if (ph == 3) begin
                // clear out and move close to the top of the time range
                for (n = 0; n < sdtq_pkg::NUM_TIMERS; n++)
                    queue_req(sdtq_pkg::MODE_DELETE, n, 0, t_cur);
                t_cur = 48'hFFFF_FFFF_0000;
            end
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 1 && n == 10)
                    queue_ctl(ACT_HOLD, '0);
                if (ph == 2 && n == 20)
                    queue_ctl(ACT_DRAIN, '0);
                t_cur = t_cur + $urandom_range(0, 40);
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    queue_req(sdtq_pkg::MODE_ONESHOT, $urandom_range(0, 15),
                              $urandom_range(0, 150), t_cur);
                end else if (r < 65) begin
                    case ($urandom_range(0, 3))
                        0: iv = 10;
                        1: iv = 20;
                        2: iv = 40;
                        default: iv = $urandom_range(0, 60);
                    endcase
                    queue_req(sdtq_pkg::MODE_PERIODIC, $urandom_range(0, 15), iv, t_cur);
                end else if (r < 75) begin
                    queue_req(sdtq_pkg::MODE_DELETE, $urandom_range(0, 15), $urandom, t_cur);
                end else if (r < 92) begin
                    queue_req(sdtq_pkg::MODE_CHECK, $urandom_range(0, 15), $urandom, t_cur);
                end else begin
                    tk = t_tick'({$urandom, $urandom});
                    queue_req(sdtq_pkg::t_mode'($urandom_range(0, 3)), $urandom_range(0, 15),
                              $urandom, tk);
                end
            end
        end
        queue_ctl(ACT_CFG, sdtq_pkg::MIN_PERIOD_RST);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk); while (!(feed_idle && rsp_drained));
        repeat (50) @(negedge clk);
        if (!rsp_drained)
            $display("%0d expected results still outstanding", expected_rsp_q.size());
        if (fail_cnt == 0 && rsp_drained)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/sdtq_pkg.sv
rtl/sdtq_req_if.sv
rtl/sdtq_rsp_if.sv
rtl/sorted_deadline_timer_queue_core.sv
test/tb_top.sv
